// ===== src/pll_pkg.sv =====
package pll_pkg;

    // Request kinds
    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_INSERT = 2'd2;
    localparam logic [1:0] REQ_REMOVE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Stream word widths, padded to whole bytes
    localparam int IN_BITS   = REQ_W + POS_W + DATA_W;
    localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = DATA_W + STAT_W + COUNT_W + 1;
    localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

    // Free pool control from the sequencer
    typedef struct packed {
        logic prep;   // fetch the top of the return stack
        logic take;   // allocate one node
        logic put;    // return one node
    } pool_ctrl_t;

endpackage

// ===== src/positional_linked_list.sv =====
// A rejected request goes from S_CHECK straight to S_RESP; any other request first
// walks its hops in S_WALK, where hops is position-1 for read/overwrite and
// position-2 for insert/remove above position 2 (else 0). One link memory read per
// hop sets the walk.
// Throughput: one request at a time; the next is taken in the cycle after the result
// is in the output register. Reset (rst_n low, async) empties the list; no clearing pass.
module positional_linked_list #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: req_type[1:0], position[8:2], item_value[40:9], zero pad
    input  logic [pll_pkg::IN_TDATA-1:0]  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: read_value[31:0], status[33:32], item_count[40:34], is_empty[41], zero pad
    output logic [pll_pkg::OUT_TDATA-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import pll_pkg::*;

    localparam int NW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_WALK, S_ACT, S_RD,
        S_INS2, S_INS3, S_REM1, S_REM2, S_RESP
    } state_t;

    state_t            state_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [SW-1:0]     item_reg;
    logic [POS_W-1:0]  steps_reg;
    logic              first_reg;
    logic [NW-1:0]     cur_reg;
    logic [NW-1:0]     nn_reg;
    logic [NW-1:0]     gone_reg;
    logic [NW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    logic [SW-1:0]     rd_reg;
    logic [STAT_W-1:0] status_reg;
    logic              m_tvalid_reg;
    logic [OUT_TDATA-1:0] m_tdata_reg;

    // Node stores
    logic [SW-1:0]     val_mem  [CAPACITY];
    logic [NW-1:0]     link_mem [CAPACITY];
    logic [SW-1:0]     val_rdata_reg;
    logic [NW-1:0]     link_rdata_reg;

    logic              val_we, val_ren, link_we, link_ren;
    logic [NW-1:0]     val_waddr, val_raddr, link_waddr, link_raddr, link_wdata;
    logic [SW-1:0]     val_wdata;

    pool_ctrl_t        pool_ctrl;
    logic [NW-1:0]     alloc_node;
    logic              pool_full;

    logic [CMPW-1:0]   pos_ext, cnt_ext;
    logic              pos_bad;
    logic              s_fire;
    logic [DATA_W-1:0] rd_word;
    logic [OUT_TDATA-1:0] resp_word;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Position range check: insert allows count+1
    assign pos_ext = CMPW'(pos_reg);
    assign cnt_ext = CMPW'(count_reg);
    always_comb
    begin
        if (req_reg == REQ_INSERT)
        begin
            pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext + CMPW'(1));
        end
        else
        begin
            pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext);
        end
    end

    // Result word
    always_comb
    begin
        rd_word          = '0;
        rd_word[SW-1:0]  = rd_reg;
        resp_word        = '0;
        resp_word[DATA_W-1:0]                        = rd_word;
        resp_word[DATA_W+STAT_W-1:DATA_W]            = status_reg;
        resp_word[DATA_W+STAT_W+COUNT_W-1:DATA_W+STAT_W] = COUNT_W'(count_reg);
        resp_word[DATA_W+STAT_W+COUNT_W]             = (count_reg == '0);
    end

    // Memory port control per sequencer step
    always_comb
    begin
        val_we     = 1'b0;
        val_waddr  = cur_reg;
        val_wdata  = item_reg;
        val_ren    = 1'b0;
        val_raddr  = (state_reg == S_REM1) ? link_rdata_reg : cur_reg;
        link_we    = 1'b0;
        link_waddr = cur_reg;
        link_wdata = nn_reg;
        link_ren   = 1'b0;
        pool_ctrl  = '0;
        if ((state_reg == S_WALK) || (state_reg == S_REM1))
        begin
            link_raddr = link_rdata_reg;
        end
        else if (state_reg == S_CHECK)
        begin
            link_raddr = head_reg;
        end
        else
        begin
            link_raddr = cur_reg;
        end

        unique case (state_reg)
            S_CHECK:
            begin
                pool_ctrl.prep = (req_reg == REQ_INSERT);
                link_ren       = 1'b1;
            end
            S_WALK:
            begin
                link_ren = (steps_reg != POS_W'(1));
            end
            S_ACT:
            begin
                unique case (req_reg)
                    REQ_READ:
                    begin
                        val_ren = 1'b1;
                    end
                    REQ_WRITE:
                    begin
                        val_we = 1'b1;
                    end
                    REQ_INSERT:
                    begin
                        pool_ctrl.take = 1'b1;
                        val_we         = 1'b1;
                        val_waddr      = alloc_node;
                        if (first_reg)
                        begin
                            link_we    = 1'b1;
                            link_waddr = alloc_node;
                            link_wdata = head_reg;
                        end
                        else
                        begin
                            link_ren = 1'b1;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        link_ren = 1'b1;
                        val_ren  = first_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_INS2:
            begin
                link_we    = 1'b1;
                link_waddr = nn_reg;
                link_wdata = link_rdata_reg;
            end
            S_INS3:
            begin
                link_we = 1'b1;
            end
            S_REM1:
            begin
                link_ren = 1'b1;
                val_ren  = 1'b1;
            end
            S_REM2:
            begin
                pool_ctrl.put = 1'b1;
                link_we       = !first_reg;
                link_wdata    = link_rdata_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Node memories
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (val_ren)
        begin
            val_rdata_reg <= val_mem[val_raddr];
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_ren)
        begin
            link_rdata_reg <= link_mem[link_raddr];
        end
    end

    pll_free_pool #(
        .CAPACITY (CAPACITY)
    ) u_pool (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (pool_ctrl),
        .put_node   (gone_reg),
        .alloc_node (alloc_node),
        .full       (pool_full)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // drop the result word once taken, unless a new one replaces it
            if (m_tvalid_reg && m_tready && (state_reg != S_RESP))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_fire)
                    begin
                        req_reg   <= s_tdata[REQ_W-1:0];
                        pos_reg   <= s_tdata[REQ_W+POS_W-1:REQ_W];
                        item_reg  <= s_tdata[REQ_W+POS_W+SW-1:REQ_W+POS_W];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    rd_reg     <= '0;
                    cur_reg    <= head_reg;
                    first_reg  <= (pos_reg == POS_W'(1));
                    if ((req_reg == REQ_INSERT) || (req_reg == REQ_REMOVE))
                    begin
                        steps_reg <= (pos_reg > POS_W'(1)) ? pos_reg - POS_W'(2) : '0;
                    end
                    else
                    begin
                        steps_reg <= pos_reg - POS_W'(1);
                    end
                    if (pos_bad)
                    begin
                        status_reg <= ST_BADPOS;
                        state_reg  <= S_RESP;
                    end
                    else if ((req_reg == REQ_INSERT) && pool_full)
                    begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_RESP;
                    end
                    else if (((req_reg == REQ_INSERT) || (req_reg == REQ_REMOVE))
                             ? (pos_reg <= POS_W'(2)) : (pos_reg == POS_W'(1)))
                    begin
                        status_reg <= ST_OK;
                        state_reg  <= S_ACT;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        state_reg  <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    // follow one link per cycle
                    cur_reg   <= link_rdata_reg;
                    steps_reg <= steps_reg - POS_W'(1);
                    if (steps_reg == POS_W'(1))
                    begin
                        state_reg <= S_ACT;
                    end
                end
                S_ACT:
                begin
                    unique case (req_reg)
                        REQ_READ:
                        begin
                            state_reg <= S_RD;
                        end
                        REQ_WRITE:
                        begin
                            state_reg <= S_RESP;
                        end
                        REQ_INSERT:
                        begin
                            nn_reg    <= alloc_node;
                            count_reg <= count_reg + CW'(1);
                            if (first_reg)
                            begin
                                head_reg  <= alloc_node;
                                state_reg <= S_RESP;
                            end
                            else
                            begin
                                state_reg <= S_INS2;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            gone_reg  <= cur_reg;
                            count_reg <= count_reg - CW'(1);
                            state_reg <= first_reg ? S_REM2 : S_REM1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_RD:
                begin
                    rd_reg    <= val_rdata_reg;
                    state_reg <= S_RESP;
                end
                S_INS2:
                begin
                    state_reg <= S_INS3;
                end
                S_INS3:
                begin
                    state_reg <= S_RESP;
                end
                S_REM1:
                begin
                    gone_reg  <= link_rdata_reg;
                    state_reg <= S_REM2;
                end
                S_REM2:
                begin
                    rd_reg <= val_rdata_reg;
                    if (first_reg)
                    begin
                        head_reg <= link_rdata_reg;
                    end
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= resp_word;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("list count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_ACT)
        && ((count_reg == $past(count_reg) + CW'(1))
        || (count_reg == $past(count_reg) - CW'(1))))
        else $error("list count changed outside a commit step");

    a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (steps_reg != '0))
        else $error("walk entered with no hops left");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> (state_reg == S_CHECK))
        else $error("accepted word did not start a request");

endmodule

// ===== src/pll_free_pool.sv =====
module pll_free_pool #(
    parameter int CAPACITY = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pll_pkg::pool_ctrl_t             ctrl,
    input  logic [$clog2(CAPACITY)-1:0]     put_node,
    output logic [$clog2(CAPACITY)-1:0]     alloc_node,
    output logic                            full
);
    import pll_pkg::*;

    localparam int NW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Returned nodes stack, plus a counter of nodes never handed out yet.
    // Pops serve returned nodes first (LIFO), then fresh nodes in order.
    logic [NW-1:0] stack_mem [CAPACITY];
    logic [NW-1:0] stack_rdata_reg;
    logic [CW-1:0] ret_top_reg;
    logic [CW-1:0] fresh_reg;
    logic [CW-1:0] ret_dec;

    assign ret_dec    = ret_top_reg - CW'(1);
    assign alloc_node = (ret_top_reg != '0) ? stack_rdata_reg : fresh_reg[NW-1:0];
    assign full       = (ret_top_reg == '0) && (fresh_reg == CW'(CAPACITY));

    // Stack memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.put)
        begin
            stack_mem[ret_top_reg[NW-1:0]] <= put_node;
        end
        if (ctrl.prep)
        begin
            stack_rdata_reg <= stack_mem[ret_dec[NW-1:0]];
        end
    end

    // Advance stack top and fresh counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ret_top_reg <= '0;
            fresh_reg   <= '0;
        end
        else
        begin
            if (ctrl.take)
            begin
                if (ret_top_reg != '0)
                begin
                    ret_top_reg <= ret_dec;
                end
                else
                begin
                    fresh_reg <= fresh_reg + CW'(1);
                end
            end
            else if (ctrl.put)
            begin
                ret_top_reg <= ret_top_reg + CW'(1);
            end
        end
    end

    a_take_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.take |-> !full)
        else $error("node taken from empty pool");

    a_no_take_and_put: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.take && ctrl.put))
        else $error("pool take and put in one cycle");

    a_pool_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (ret_top_reg <= CW'(CAPACITY)) && (fresh_reg <= CW'(CAPACITY))
        && (ret_top_reg <= fresh_reg))
        else $error("free pool counters out of range");

endmodule
